// ===== hdl/srtt_pkg.sv =====
`timescale 1ns / 1ps

package srtt_pkg;

    // fixed geometry of the converter
    localparam int VALUE_BITS   = 32;
    localparam int ALPHA_CHARS  = 16;
    localparam int DIGIT_BITS   = 4;
    localparam int CHAR_BITS    = 8;
    localparam int RADIX_BITS   = 5;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int CNT_BITS     = 6;   // holds 0..VALUE_BITS
    localparam int SLOT_BITS    = 5;   // digit stack index

    // character codes
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ALPHA_HIGH = 2'd2;

    typedef struct packed {
        logic [RADIX_BITS-1:0]    radix;
        logic [CFG_DATA_BITS-1:0] alpha_low;
        logic [CFG_DATA_BITS-1:0] alpha_high;
    } cfg_t;

    // one classified item on its way to the converter
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_EMIT
    } bk_state_t;

    function automatic logic [CHAR_BITS-1:0] alpha_char(
        input cfg_t                  cfg,
        input logic [DIGIT_BITS-1:0] idx
    );
        logic [CFG_DATA_BITS-1:0] word;
        word = idx[3] ? cfg.alpha_high : cfg.alpha_low;
        return word[{idx[2:0], 3'b000} +: CHAR_BITS];
    endfunction

endpackage

// ===== hdl/srtt_front.sv =====
`timescale 1ns / 1ps

// Accepts values, checks the alphabet setup, folds the sign off.
module srtt_front #(
    parameter int MAX_RADIX = 16
) (
    input  srtt_pkg::cfg_t                        cfg,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [srtt_pkg::VALUE_BITS-1:0] s_value,
    input  logic                                  q_full,
    output logic                                  q_push,
    output srtt_pkg::item_t                       q_item
);

    logic cfg_ok;
    logic [srtt_pkg::CHAR_BITS-1:0] ch [srtt_pkg::ALPHA_CHARS];
    logic [srtt_pkg::ALPHA_CHARS-1:0] active;

    always_comb begin
        for (int i = 0; i < srtt_pkg::ALPHA_CHARS; i++) begin
            ch[i]     = srtt_pkg::alpha_char(cfg, srtt_pkg::DIGIT_BITS'(i));
            active[i] = (srtt_pkg::RADIX_BITS'(i) < cfg.radix);
        end
    end

    // radix range, no sign chars, all pairs of digits in use distinct
    always_comb begin
        cfg_ok = (cfg.radix >= srtt_pkg::RADIX_BITS'(2))
              && (cfg.radix <= srtt_pkg::RADIX_BITS'(MAX_RADIX))
              && (cfg.radix <= srtt_pkg::RADIX_BITS'(srtt_pkg::ALPHA_CHARS));
        for (int i = 0; i < srtt_pkg::ALPHA_CHARS; i++) begin
            if (active[i] && (ch[i] == srtt_pkg::CH_PLUS || ch[i] == srtt_pkg::CH_MINUS)) begin
                cfg_ok = 1'b0;
            end
            for (int j = i + 1; j < srtt_pkg::ALPHA_CHARS; j++) begin
                if (active[j] && ch[i] == ch[j]) begin
                    cfg_ok = 1'b0;
                end
            end
        end
    end

    assign s_ready = !q_full;

    // items under a bad setup are taken and dropped
    assign q_push     = s_valid && !q_full && cfg_ok;
    assign q_item.neg = s_value[srtt_pkg::VALUE_BITS-1];
    assign q_item.mag = s_value[srtt_pkg::VALUE_BITS-1]
                      ? (~s_value + srtt_pkg::VALUE_BITS'(1)) : s_value;

endmodule

// ===== hdl/srtt_queue.sv =====
`timescale 1ns / 1ps

// Two-entry queue between classifier and converter.
module srtt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  srtt_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output srtt_pkg::item_t pop_item
);

    srtt_pkg::item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/srtt_back.sv =====
`timescale 1ns / 1ps

// Repeated division by the radix, one byte per cycle, digits stacked,
// then emitted most significant first.
module srtt_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  srtt_pkg::cfg_t                     cfg,
    input  logic                               q_not_empty,
    input  srtt_pkg::item_t                    q_item,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [srtt_pkg::CHAR_BITS-1:0]     m_char_out,
    output logic                               m_last
);

    localparam int STACK_DEPTH = srtt_pkg::VALUE_BITS;

    // one byte of long division: 8 restoring steps, remainder stays < radix
    function automatic logic [11:0] div_byte(
        input logic [3:0] rem_in,
        input logic [7:0] byte_in,
        input logic [4:0] dv
    );
        logic [4:0] t;
        logic [3:0] r;
        logic [7:0] q;
        r = rem_in;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {r, byte_in[i]};
            if (t >= dv) begin
                q[i] = 1'b1;
                t    = t - dv;
            end
            r = t[3:0];
        end
        return {q, r};
    endfunction

    srtt_pkg::bk_state_t state_reg, state_next;

    logic [srtt_pkg::VALUE_BITS-1:0] work_reg, work_next;
    logic [srtt_pkg::DIGIT_BITS-1:0] rem_reg,  rem_next;
    logic [1:0]                      step_reg, step_next;
    logic [srtt_pkg::CNT_BITS-1:0]   cnt_reg,  cnt_next;
    logic                            neg_reg,  neg_next;

    logic                            m_valid_reg, m_valid_next;
    logic [srtt_pkg::CHAR_BITS-1:0]  m_char_reg,  m_char_next;
    logic                            m_last_reg,  m_last_next;

    logic [srtt_pkg::DIGIT_BITS-1:0] stack [STACK_DEPTH];
    logic [srtt_pkg::DIGIT_BITS-1:0] rd_data_reg;
    logic                            mem_we;
    logic [srtt_pkg::SLOT_BITS-1:0]  wr_addr;
    logic [srtt_pkg::SLOT_BITS-1:0]  rd_addr;
    logic [srtt_pkg::CNT_BITS-1:0]   cnt_dec;

    logic [11:0]                     dstep;
    logic [srtt_pkg::VALUE_BITS-1:0] quot;
    logic                            out_free;

    assign dstep    = div_byte(rem_reg, work_reg[srtt_pkg::VALUE_BITS-1 -: 8], cfg.radix);
    assign quot     = {work_reg[srtt_pkg::VALUE_BITS-9:0], dstep[11:4]};
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_dec  = cnt_reg - srtt_pkg::CNT_BITS'(1);
    assign wr_addr  = cnt_reg[srtt_pkg::SLOT_BITS-1:0];
    assign rd_addr  = cnt_dec[srtt_pkg::SLOT_BITS-1:0];

    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        mem_we       = 1'b0;

        case (state_reg)
            srtt_pkg::BK_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    work_next  = q_item.mag;
                    neg_next   = q_item.neg;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = srtt_pkg::BK_DIV;
                end
            end
            srtt_pkg::BK_DIV: begin
                work_next = quot;
                rem_next  = dstep[3:0];
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    // full pass done: remainder is the next digit
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + srtt_pkg::CNT_BITS'(1);
                    rem_next = '0;
                    if (quot == '0) begin
                        state_next = neg_reg ? srtt_pkg::BK_SIGN : srtt_pkg::BK_READ;
                    end
                end
            end
            srtt_pkg::BK_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = srtt_pkg::CH_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = srtt_pkg::BK_READ;
                end
            end
            srtt_pkg::BK_READ: begin
                cnt_next   = cnt_dec;
                state_next = srtt_pkg::BK_EMIT;
            end
            srtt_pkg::BK_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = srtt_pkg::alpha_char(cfg, rd_data_reg);
                    m_last_next  = (cnt_reg == '0);
                    state_next   = (cnt_reg == '0) ? srtt_pkg::BK_IDLE : srtt_pkg::BK_READ;
                end
            end
            default: begin
                state_next = srtt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srtt_pkg::BK_IDLE;
            cnt_reg     <= '0;
            step_reg    <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            neg_reg     <= neg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    // digit stack
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack[wr_addr] <= dstep[3:0];
        end
        if (state_reg == srtt_pkg::BK_READ) begin
            rd_data_reg <= stack[rd_addr];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;
    assign m_last     = m_last_reg;

endmodule

// ===== hdl/signed_radix_to_text_top.sv =====
`timescale 1ns / 1ps

// Signed value to text in a configurable radix.
// Input channel (s_valid/s_ready/s_value): one signed 32-bit value per
// transfer. Output channel (m_valid/m_ready/m_char_out/m_last): one character
// per transfer, most significant digit first, a leading '-' for negative
// values, m_last high on the final digit.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 radix,
// 1 digits 0..7, 2 digits 8..15, one byte each); other indexes are ignored.
// Write only while the block is idle. With a radix outside 2..MAX_RADIX, a
// '+' or '-' among the digits in use, or any two equal digits, values are
// taken and produce no output.
// Flow: the divider handles one byte of the long division per cycle, a full
// pass over the value giving each digit; each character then takes a stack
// read (BK_READ) and an emit (BK_EMIT), with BK_SIGN first for a '-'.
// One value is converted at a time; a two-entry queue in front lets up to
// two more values be taken while the converter is busy.
// A stalled receiver holds the output register and stops the converter at its
// next character; the input side keeps filling the queue until it is full.
// Reset (synchronous, active low) empties the queue, idles the converter,
// drops any pending character and clears all configuration registers.
module signed_radix_to_text_top #(
    parameter int MAX_RADIX = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [srtt_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [srtt_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [srtt_pkg::VALUE_BITS-1:0] s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [srtt_pkg::CHAR_BITS-1:0]         m_char_out,
    output logic                                   m_last
);

    srtt_pkg::cfg_t  cfg_reg;
    srtt_pkg::item_t push_item;
    srtt_pkg::item_t pop_item;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_not_empty;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                srtt_pkg::CFG_RADIX: begin
                    cfg_reg.radix <= cfg_wdata[srtt_pkg::RADIX_BITS-1:0];
                end
                srtt_pkg::CFG_ALPHA_LOW: begin
                    cfg_reg.alpha_low <= cfg_wdata;
                end
                srtt_pkg::CFG_ALPHA_HIGH: begin
                    cfg_reg.alpha_high <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // classify: setup check, sign and magnitude
    srtt_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (push_item)
    );

    srtt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    // convert and emit
    srtt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_last      (m_last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Converter testbench: a built-in predictor renders every accepted value under a
// usable setup as text in the current radix and alphabet. The checker compares
// each output transfer, character and last flag, with the oldest predicted character.
module tb;

    localparam int MAX_RADIX    = 16;
    localparam int DRAIN_CYCLES = 640;     // three values in flight
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_ITEMS = 76;

    // register index with no register behind it; writes must be dropped
    localparam logic [srtt_pkg::CFG_ADDR_BITS-1:0] CFG_UNUSED = 2'd3;

    // "0123456789ABCDEF", digit 0 in the low byte
    localparam logic [63:0] HEX_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] HEX_HIGH = 64'h4645_4443_4241_3938;
    // raw byte values 0x00..0x0F, so digit 0 is a zero byte
    localparam logic [63:0] RAW_LOW  = 64'h0706_0504_0302_0100;
    localparam logic [63:0] RAW_HIGH = 64'h0F0E_0D0C_0B0A_0908;

    typedef struct packed {
        logic [srtt_pkg::CHAR_BITS-1:0] glyph;
        logic                           last;
    } text_char_t;

    // ---------------------------------------------------------------- DUT I/O
    logic                                   aclk;
    logic                                   aresetn;
    logic                                   cfg_wr_en;
    logic [srtt_pkg::CFG_ADDR_BITS-1:0]     cfg_addr;
    logic [srtt_pkg::CFG_DATA_BITS-1:0]     cfg_wdata;
    logic                                   s_valid;
    logic                                   s_ready;
    logic signed [srtt_pkg::VALUE_BITS-1:0] s_value;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic [srtt_pkg::CHAR_BITS-1:0]         m_char_out;
    logic                                   m_last;

    signed_radix_to_text_top #(
        .MAX_RADIX(MAX_RADIX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_char_out(m_char_out),
        .m_last    (m_last)
    );

    // ------------------------------------------------------ predictor state
    logic [srtt_pkg::RADIX_BITS-1:0] radix_reg;         // shadow of the radix register
    logic [srtt_pkg::CHAR_BITS-1:0]  digit_glyph [16];  // shadow of both alphabet words
    text_char_t                      pending_text [$];  // characters still to arrive

    int fail_count      = 0;
    int values_sent     = 0;
    int random_sent     = 0;
    int chars_checked   = 0;
    int config_changes  = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    text_char_t next_char;

    // ------------------------------------------------------------- clocking
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: a hung handshake or a lost character ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** signed_radix_to_text_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------ receiver stalls
    // A 16-bit ready pattern is replayed; every so often a new one is drawn:
    // always ready, random, mostly ready, or long stalls (a single ready bit).
    logic [15:0] stall_pat  = 16'hFFFF;
    logic [3:0]  stall_idx  = 4'd0;
    int          stall_span = 0;

    always @(posedge aclk) begin
        m_ready   <= stall_pat[stall_idx];
        stall_idx <= stall_idx + 4'd1;
        if (stall_span == 0) begin
            stall_span <= $urandom_range(20, 150);
            case ($urandom_range(0, 3))
                0: begin
                    stall_pat <= 16'hFFFF;
                end
                1: begin
                    stall_pat <= 16'($urandom) | 16'h0001;
                end
                2: begin
                    stall_pat <= 16'h0001;
                end
                default: begin
                    stall_pat <= 16'($urandom) | 16'($urandom) | 16'h0100;
                end
            endcase
        end else begin
            stall_span <= stall_span - 1;
        end
    end

    // ------------------------------------------------------------- checker
    // Inputs are sampled right after the edge, i.e. the values the DUT saw.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_text.size() == 0) begin
                $error("unexpected character: char_out actual %h, last actual %b",
                       m_char_out, m_last);
                fail_count++;
            end else begin
                next_char = pending_text.pop_front();
                chars_checked++;
                if (m_char_out !== next_char.glyph) begin
                    $error("char_out mismatch: expected %h, actual %h",
                           next_char.glyph, m_char_out);
                    fail_count++;
                end
                if (m_last !== next_char.last) begin
                    $error("last mismatch: expected %b, actual %b",
                           next_char.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------ predictor
    // Config is usable only for radix 2..MAX_RADIX, no sign characters among
    // the digits in use, and no two equal digits anywhere in that range.
    function automatic bit alphabet_usable();
        int n;
        n = int'(radix_reg);
        if (n < 2 || n > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (digit_glyph[i] == srtt_pkg::CH_PLUS || digit_glyph[i] == srtt_pkg::CH_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (digit_glyph[j] == digit_glyph[i])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_text(input logic signed [srtt_pkg::VALUE_BITS-1:0] v);
        logic [srtt_pkg::VALUE_BITS-1:0] mag;
        logic [srtt_pkg::VALUE_BITS-1:0] base;
        logic [srtt_pkg::DIGIT_BITS-1:0] digits [$];
        text_char_t                      c;
        if (!alphabet_usable())
            return;
        base = srtt_pkg::VALUE_BITS'(radix_reg);
        // two's complement magnitude; the most negative value gives 2^31
        mag  = v[srtt_pkg::VALUE_BITS-1] ? (~v + 32'd1) : v;
        do begin
            digits.push_front(srtt_pkg::DIGIT_BITS'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        if (v[srtt_pkg::VALUE_BITS-1]) begin
            c.glyph = srtt_pkg::CH_MINUS;
            c.last  = 1'b0;
            pending_text.push_back(c);
        end
        foreach (digits[i]) begin
            c.glyph = digit_glyph[digits[i]];
            c.last  = (i == digits.size() - 1);
            pending_text.push_back(c);
        end
    endtask

    // ------------------------------------------------------- shared drivers
    // Valid is lowered only at the start of a gap, so back-to-back transfers
    // never see a low and a high assignment in the same time step.
    task automatic send_value(input logic signed [srtt_pkg::VALUE_BITS-1:0] v);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        predict_text(v);
        values_sent++;
        burst_left--;
    endtask

    // Stop sending, wait for every predicted character, then let anything
    // that produces no output finish inside the DUT.
    task automatic quiesce();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_text.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [srtt_pkg::CFG_ADDR_BITS-1:0] addr,
                             input logic [srtt_pkg::CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (addr)
            srtt_pkg::CFG_RADIX: begin
                radix_reg = data[srtt_pkg::RADIX_BITS-1:0];
            end
            srtt_pkg::CFG_ALPHA_LOW: begin
                for (int i = 0; i < 8; i++) digit_glyph[i] = data[8*i +: 8];
            end
            srtt_pkg::CFG_ALPHA_HIGH: begin
                for (int i = 0; i < 8; i++) digit_glyph[8+i] = data[8*i +: 8];
            end
            default: begin
            end
        endcase
    endtask

    // Full reconfiguration; upper radix bits carry junk the DUT must drop.
    task automatic load_config(input logic [srtt_pkg::RADIX_BITS-1:0] radix,
                               input logic [63:0] lo, input logic [63:0] hi);
        write_reg(srtt_pkg::CFG_ALPHA_LOW, lo);
        write_reg(srtt_pkg::CFG_ALPHA_HIGH, hi);
        write_reg(srtt_pkg::CFG_RADIX, {59'({$urandom, $urandom}), radix});
        config_changes++;
    endtask

    // Sixteen distinct random bytes, never a sign character.
    task automatic pick_glyphs(output logic [63:0] lo, output logic [63:0] hi);
        bit                             taken [256];
        logic [srtt_pkg::CHAR_BITS-1:0] g;
        for (int i = 0; i < 16; i++) begin
            do g = 8'($urandom);
            while (taken[g] || g == srtt_pkg::CH_PLUS || g == srtt_pkg::CH_MINUS);
            taken[g] = 1'b1;
            if (i < 8) lo[8*i +: 8] = g;
            else       hi[8*(i-8) +: 8] = g;
        end
    endtask

    // Mix of full-range, small, digit-count boundary and extreme values.
    function automatic logic signed [srtt_pkg::VALUE_BITS-1:0] pick_value();
        logic [srtt_pkg::VALUE_BITS-1:0] u;
        logic [srtt_pkg::VALUE_BITS-1:0] p;
        logic [srtt_pkg::VALUE_BITS-1:0] base;
        int                              sel;
        base = (radix_reg < 2 || radix_reg > MAX_RADIX) ? 32'd10 : 32'(radix_reg);
        sel  = $urandom_range(0, 5);
        case (sel)
            0, 1: begin
                u = $urandom;
            end
            2: begin
                u = $urandom_range(0, 40);
            end
            3: begin
                // radix^k or radix^k - 1, where the digit count steps
                p = 32'd1;
                repeat ($urandom_range(1, 31))
                    if (p <= 32'hFFFF_FFFF / base) p = p * base;
                u = p - 32'($urandom_range(0, 1));
            end
            4: begin
                u = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            default: begin
                u = $urandom >> $urandom_range(0, 31);
            end
        endcase
        if (sel != 4 && sel > 1 && $urandom_range(0, 1))
            u = ~u + 32'd1;
        return u;
    endfunction

    // ----------------------------------------------------------- the tests
    // Registers come out of reset as zero: radix 0, so values are swallowed.
    task automatic test_reset_defaults();
        send_value(32'sd5);
        send_value(-32'sd5);
        quiesce();
    endtask

    // Decimal: zero, one digit, sign, digit-count steps, both extremes.
    task automatic test_decimal();
        load_config(5'd10, HEX_LOW, HEX_HIGH);
        send_value(32'sd0);
        send_value(32'sd7);
        send_value(-32'sd1);
        send_value(32'sd10);
        send_value(-32'sd10);
        send_value(32'sd99);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        quiesce();
    endtask

    // Radix 2: the most negative value gives the longest text, 33 characters.
    task automatic test_binary_extremes();
        load_config(5'd2, HEX_LOW, HEX_HIGH);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(-32'sd1);
        quiesce();
    endtask

    // Full 16-character alphabet of raw bytes; digit 0 is a zero byte.
    task automatic test_full_alphabet();
        load_config(5'd16, RAW_LOW, RAW_HIGH);
        send_value(32'sd0);
        send_value(32'sd255);
        send_value(-32'sd256);
        send_value(pick_value());
        quiesce();
    endtask

    // Each rejected configuration swallows values; a sign character or a
    // repeat outside the digits in use is harmless.
    task automatic test_bad_configs();
        logic [63:0] lo;
        logic [63:0] hi;
        load_config(5'd1, HEX_LOW, HEX_HIGH);
        send_value(32'sd3);
        quiesce();
        load_config(5'd17, HEX_LOW, HEX_HIGH);
        send_value(-32'sd3);
        quiesce();
        load_config(5'd31, HEX_LOW, HEX_HIGH);
        send_value(32'sd12345);
        quiesce();
        lo = HEX_LOW;
        lo[3*8 +: 8] = srtt_pkg::CH_PLUS;
        load_config(5'd10, lo, HEX_HIGH);
        send_value(32'sd42);
        quiesce();
        hi = HEX_HIGH;
        hi[7*8 +: 8] = srtt_pkg::CH_MINUS;      // last digit of radix 16
        load_config(5'd16, HEX_LOW, hi);
        send_value(-32'sd42);
        quiesce();
        hi = HEX_HIGH;
        hi[4*8 +: 8] = HEX_LOW[7:0];            // digit 12 repeats digit 0
        load_config(5'd16, HEX_LOW, hi);
        send_value(32'sd1000);
        quiesce();
        hi[7*8 +: 8] = srtt_pkg::CH_PLUS;       // both flaws beyond radix 10
        load_config(5'd10, HEX_LOW, hi);
        send_value(-32'sd1000);
        quiesce();
    endtask

    // Writes to the unused index must not touch any register.
    task automatic test_unused_index();
        load_config(5'd8, HEX_LOW, HEX_HIGH);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        write_reg(CFG_UNUSED, 64'h0);
        send_value(-32'sd4095);
        quiesce();
    endtask

    // Random phases: mostly valid alphabets of random radix, some rejected.
    task automatic test_random_phases();
        logic [63:0]                     lo;
        logic [63:0]                     hi;
        logic [srtt_pkg::RADIX_BITS-1:0] radix;
        int                              flaw;
        int                              a;
        int                              b;
        int                              count;
        while (random_sent < RANDOM_ITEMS) begin
            pick_glyphs(lo, hi);
            case ($urandom_range(0, 5))
                0:       radix = 5'd2;
                1:       radix = 5'd16;
                default: radix = 5'($urandom_range(2, 16));
            endcase
            flaw = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
            a = $urandom_range(0, int'(radix) - 1);
            b = $urandom_range(0, int'(radix) - 1);
            case (flaw)
                1: begin
                    radix = $urandom_range(0, 1) ? 5'($urandom_range(0, 1))
                                                 : 5'($urandom_range(17, 31));
                end
                2: begin
                    if (a < 8) lo[8*a +: 8] = $urandom_range(0, 1) ? srtt_pkg::CH_PLUS
                                                                   : srtt_pkg::CH_MINUS;
                    else       hi[8*(a-8) +: 8] = $urandom_range(0, 1) ? srtt_pkg::CH_PLUS
                                                                       : srtt_pkg::CH_MINUS;
                end
                3: begin
                    if (a == b) b = (a + 1) % int'(radix);
                    if (b < 8) lo[8*b +: 8] = (a < 8) ? lo[8*a +: 8] : hi[8*(a-8) +: 8];
                    else       hi[8*(b-8) +: 8] = (a < 8) ? lo[8*a +: 8] : hi[8*(a-8) +: 8];
                end
                default: begin
                end
            endcase
            load_config(radix, lo, hi);
            count = (flaw != 0) ? $urandom_range(1, 3) : $urandom_range(6, 18);
            repeat (count) begin
                send_value(pick_value());
                if (flaw == 0) random_sent++;
            end
            quiesce();
        end
    endtask

    // ---------------------------------------------------------- main flow
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = srtt_pkg::CFG_RADIX;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_value   = '0;
        radix_reg = '0;
        foreach (digit_glyph[i]) digit_glyph[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_decimal();
        test_binary_extremes();
        test_full_alphabet();
        test_bad_configs();
        test_unused_index();
        test_random_phases();

        if (pending_text.size() != 0) begin
            $error("%0d characters never arrived", pending_text.size());
            fail_count++;
        end
        $display("covered %0d values over %0d configurations, radix 0..31 incl. rejects",
                 values_sent, config_changes);
        $display("%0d characters compared, %0d mismatches", chars_checked, fail_count);
        if (fail_count == 0) begin
            $display("** signed_radix_to_text_top: PASSED **");
        end else begin
            $display("** signed_radix_to_text_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/srtt_pkg.sv
hdl/srtt_front.sv
hdl/srtt_queue.sv
hdl/srtt_back.sv
hdl/signed_radix_to_text_top.sv
tb/tb.sv
